// ===== hw/rtl/pmst_pkg.sv =====
// shared types, constants and codes for the minimum spanning tree engine
package pmst_pkg;

   localparam int MAX_VERTICES_DEF  = 16;
   localparam int WEIGHT_BITS_DEF   = 16;
   localparam int VERTEX_BITS       = 4;
   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int TOTAL_BITS        = 20;
   localparam int COUNT_BITS        = 5;
   localparam int CMP_BITS          = 8;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_RUN  = 1'b1;

   typedef enum logic [1:0] {
      STAT_START   = 2'd0,
      STAT_JOINED  = 2'd1,
      STAT_UNREACH = 2'd2
   } stat_type;

   typedef struct packed {
      logic                         func;
      logic [VERTEX_BITS-1:0]       vertex_a;
      logic [VERTEX_BITS-1:0]       vertex_b;
      logic [WEIGHT_FIELD_BITS-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0]       vertex;
      logic [VERTEX_BITS-1:0]       parent;
      stat_type                     status;
      logic [WEIGHT_FIELD_BITS-1:0] edge_weight;
      logic [TOTAL_BITS-1:0]        total_cost;
      logic                         last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EDGE_A,
      S_EDGE_B,
      S_INIT,
      S_RELAX,
      S_RELAX_END,
      S_PICK,
      S_OUT,
      S_OUT_END
   } fsm_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic edge_wr_a;
      logic edge_wr_b;
      logic issue;
      logic init_mode;
      logic out_mode;
      logic pass_start;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic item_ok;
      logic req_run;
      logic cnt_last;
      logic pick_valid;
   } sts_type;

endpackage

// ===== hw/rtl/pmst_dp.sv =====
// datapath: weight matrix, per-vertex tree state, scan pipeline and result register
module pmst_dp #(
   parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pmst_pkg::cmd_type                   cmd,
   output pmst_pkg::sts_type                   sts,
   input  pmst_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [pmst_pkg::COUNT_BITS-1:0]     csr_data,
   output logic                                rsp_strobe,
   output pmst_pkg::rsp_type                   rsp_data
);
   import pmst_pkg::*;

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int AW    = 2 * VW;
   localparam int DEPTH = 1 << AW;
   localparam int CB    = WEIGHT_BITS + 1;

   logic [COUNT_BITS-1:0]  count_ff;
   logic [CMP_BITS-1:0]    n_act;
   logic [VW-1:0]          n_m1;

   logic [WEIGHT_BITS-1:0] adj_mem [DEPTH];
   logic [WEIGHT_BITS-1:0] adj_rd_ff;
   logic                   adj_we;
   logic [AW-1:0]          adj_wa;
   logic [WEIGHT_BITS-1:0] adj_wd;

   logic                   tree_mem [MAX_VERTICES];
   logic [CB-1:0]          cost_mem [MAX_VERTICES];
   logic [VW-1:0]          par_mem  [MAX_VERTICES];
   logic                   tree_rd_ff;
   logic [CB-1:0]          cost_rd_ff;
   logic [VW-1:0]          par_rd_ff;

   logic [AW-1:0]          clr_ff;
   logic [VW-1:0]          cnt_ff;
   logic                   s1_valid_ff;
   logic                   s1_init_ff;
   logic                   s1_out_ff;
   logic [VW-1:0]          s1_idx_ff;

   logic [VW-1:0]          start_ff;
   logic [VW-1:0]          row_ff;
   logic [VW-1:0]          a_ff;
   logic [VW-1:0]          b_ff;
   logic [WEIGHT_BITS-1:0] w_ff;
   logic [TOTAL_BITS-1:0]  total_ff;
   logic [CB-1:0]          cand_cost_ff;
   logic [VW-1:0]          cand_idx_ff;

   logic                   old_tree;
   logic [CB-1:0]          old_cost;
   logic [VW-1:0]          old_par;
   logic                   at_row;
   logic                   upd;
   logic                   tree_in;
   logic [CB-1:0]          cost_in;
   logic [VW-1:0]          par_in;
   logic                   cand_take;
   logic                   st_we;

   logic                   rsp_strobe_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   // vertex count saturated into 2 .. MAX_VERTICES
   always_comb begin
      if (count_ff < COUNT_BITS'(2)) begin
         n_act = CMP_BITS'(2);
      end else if (CMP_BITS'(count_ff) > CMP_BITS'(MAX_VERTICES)) begin
         n_act = CMP_BITS'(MAX_VERTICES);
      end else begin
         n_act = CMP_BITS'(count_ff);
      end
   end
   assign n_m1 = VW'(n_act - CMP_BITS'(1));

   always_comb begin
      sts.clr_last   = &clr_ff;
      sts.req_run    = (req_data.func == FUNC_RUN);
      sts.cnt_last   = (cnt_ff == n_m1);
      sts.pick_valid = (cand_cost_ff != {CB{1'b1}});
      if (req_data.func == FUNC_EDGE) begin
         sts.item_ok = (CMP_BITS'(req_data.vertex_a) < n_act)
                    && (CMP_BITS'(req_data.vertex_b) < n_act);
      end else begin
         sts.item_ok = (CMP_BITS'(req_data.vertex_a) < n_act);
      end
   end

   // matrix write port: clearing sweep or the two mirrored edge writes
   always_comb begin
      adj_we = cmd.clear || cmd.edge_wr_a || cmd.edge_wr_b;
      if (cmd.clear) begin
         adj_wa = clr_ff;
         adj_wd = '0;
      end else if (cmd.edge_wr_a) begin
         adj_wa = {a_ff, b_ff};
         adj_wd = w_ff;
      end else begin
         adj_wa = {b_ff, a_ff};
         adj_wd = w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= adj_wd;
      end
      adj_rd_ff <= adj_mem[{row_ff, cnt_ff}];
   end

   // relaxation of one vertex; the first pass sees cleared state
   always_comb begin
      old_tree  = s1_init_ff ? 1'b0 : tree_rd_ff;
      old_cost  = s1_init_ff ? {CB{1'b1}} : cost_rd_ff;
      old_par   = s1_init_ff ? '0 : par_rd_ff;
      at_row    = (s1_idx_ff == row_ff);
      upd       = !at_row && !old_tree && (adj_rd_ff != '0)
               && ({1'b0, adj_rd_ff} < old_cost);
      tree_in   = old_tree | at_row;
      cost_in   = upd ? {1'b0, adj_rd_ff} : old_cost;
      par_in    = upd ? row_ff : old_par;
      cand_take = !tree_in && (cost_in < cand_cost_ff);
      st_we     = s1_valid_ff && !s1_out_ff;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         tree_mem[s1_idx_ff] <= tree_in;
         cost_mem[s1_idx_ff] <= cost_in;
         par_mem[s1_idx_ff]  <= par_in;
      end
      tree_rd_ff <= tree_mem[cnt_ff];
      cost_rd_ff <= cost_mem[cnt_ff];
      par_rd_ff  <= par_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= COUNT_RESET;
         clr_ff        <= '0;
         cnt_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_data;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.capture) begin
            cnt_ff <= '0;
         end else if (cmd.issue) begin
            cnt_ff <= sts.cnt_last ? '0 : cnt_ff + VW'(1);
         end
         s1_valid_ff   <= cmd.issue;
         rsp_strobe_ff <= s1_valid_ff && s1_out_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_init_ff <= cmd.init_mode;
      s1_out_ff  <= cmd.out_mode;
      s1_idx_ff  <= cnt_ff;
      if (cmd.capture) begin
         start_ff     <= VW'(req_data.vertex_a);
         row_ff       <= VW'(req_data.vertex_a);
         a_ff         <= VW'(req_data.vertex_a);
         b_ff         <= VW'(req_data.vertex_b);
         w_ff         <= WEIGHT_BITS'(req_data.weight);
         total_ff     <= '0;
         cand_cost_ff <= {CB{1'b1}};
      end else if (cmd.pass_start) begin
         if (sts.pick_valid) begin
            row_ff   <= cand_idx_ff;
            total_ff <= total_ff + TOTAL_BITS'(cand_cost_ff);
         end
         cand_cost_ff <= {CB{1'b1}};
      end else if (st_we && cand_take) begin
         cand_cost_ff <= cost_in;
         cand_idx_ff  <= s1_idx_ff;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_in.vertex = VERTEX_BITS'(s1_idx_ff);
      if (s1_idx_ff == start_ff) begin
         rsp_in.status      = STAT_START;
         rsp_in.parent      = '0;
         rsp_in.edge_weight = '0;
      end else if (tree_rd_ff) begin
         rsp_in.status      = STAT_JOINED;
         rsp_in.parent      = VERTEX_BITS'(par_rd_ff);
         rsp_in.edge_weight = WEIGHT_FIELD_BITS'(cost_rd_ff);
      end else begin
         rsp_in.status      = STAT_UNREACH;
         rsp_in.parent      = '0;
         rsp_in.edge_weight = '0;
      end
      rsp_in.last       = (s1_idx_ff == n_m1);
      rsp_in.total_cost = rsp_in.last ? total_ff : '0;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hw/rtl/pmst_ctrl.sv =====
// controller state machine sequencing clear, edge writes, scan passes and result output
module pmst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pmst_pkg::sts_type sts,
   output logic              busy,
   output pmst_pkg::cmd_type cmd
);
   import pmst_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start && sts.item_ok) begin
               state_in = sts.req_run ? S_INIT : S_EDGE_A;
            end
         end
         S_EDGE_A:    state_in = S_EDGE_B;
         S_EDGE_B:    state_in = S_IDLE;
         S_INIT: begin
            if (sts.cnt_last) state_in = S_RELAX_END;
         end
         S_RELAX: begin
            if (sts.cnt_last) state_in = S_RELAX_END;
         end
         S_RELAX_END: state_in = S_PICK;
         S_PICK:      state_in = sts.pick_valid ? S_RELAX : S_OUT;
         S_OUT: begin
            if (sts.cnt_last) state_in = S_OUT_END;
         end
         S_OUT_END:   state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      busy           = 1'b1;
      case (state_ff)
         S_CLEAR:  cmd.clear = 1'b1;
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_EDGE_A: cmd.edge_wr_a = 1'b1;
         S_EDGE_B: cmd.edge_wr_b = 1'b1;
         S_INIT: begin
            cmd.issue     = 1'b1;
            cmd.init_mode = 1'b1;
         end
         S_RELAX:  cmd.issue = 1'b1;
         S_PICK:   cmd.pass_start = 1'b1;
         S_OUT: begin
            cmd.issue    = 1'b1;
            cmd.out_mode = 1'b1;
         end
         default: begin
            cmd  = '0;
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== hw/rtl/prim_minimum_spanning_tree.sv =====
// top level: Prim minimum spanning tree engine over a cleared-at-reset weight matrix
// edge beat: busy after acceptance for the two mirrored writes (S_EDGE_A, S_EDGE_B) on one matrix port
// run beat: busy through the init scan pass, one relax pass per vertex picked, and the output pass
// each scan pass walks one matrix row through the single read port, one vertex per cycle
// results: one beat per active vertex on consecutive cycles, last one in the first idle cycle; receiver cannot stall
// reset: matrix clearing sweep over all 4^ceil(log2(MAX_VERTICES)) entries (256 at default), busy held
module prim_minimum_spanning_tree #(
   parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  pmst_pkg::req_type               req_data,
   // result channel, one beat per cycle, no back-pressure
   output logic                            rsp_strobe,
   output pmst_pkg::rsp_type               rsp_data,
   // vertex count register
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pmst_pkg::COUNT_BITS-1:0] csr_data
);
   import pmst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // the register is always writable; the user must change it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   // sequencing: clear sweep, edge writes, scan passes, output pass
   pmst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   // matrix, per-vertex state memories, scan stage and result register
   pmst_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .csr_we     (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // results of one run come out back to back until the last
   a_rsp_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("result beats of one run not contiguous");

   // nothing follows the last beat directly
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !rsp_strobe)
      else $error("result beat directly after last");

   // total only on the last beat
   a_total_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> rsp_data.total_cost == '0)
      else $error("total cost on a non-final beat");

   // a joined vertex always came in over a real edge, others carry no edge
   a_edge_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.status == STAT_JOINED) == (rsp_data.edge_weight != '0)))
      else $error("edge weight inconsistent with status");

   // no results while a new command is being taken, unless busy or a beat came just before
   a_no_rsp_at_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !$past(busy) && !$past(rsp_strobe) |-> !rsp_strobe)
      else $error("result beat with no run in flight");

endmodule
